FILE: sv/lzwst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzwst_pkg: shared types and constants of the LZW string table
// Table size, field widths, command codes and sequencer states.
// ----------------------------------------------------------------------------
package lzwst_pkg;

  // Number of table slots; any value from 256 to 65536 works.
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int CMD_W     = 2;
  localparam int PREFIX_W  = 12;
  localparam int PIXEL_W   = 8;
  localparam int CODE_W    = 12;
  localparam int PIX_SHIFT = 4;

  // Hash value before reduction, one bit wider than the wider of the prefix code and the index.
  localparam int HASH_W = ((PREFIX_W > IDX_W) ? PREFIX_W : IDX_W) + 1;

  // Table row: {prefix, pixel, code}
  localparam int ROW_W = PREFIX_W + PIXEL_W + CODE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEARCH = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_CLEAR
  } state_t;

endpackage : lzwst_pkg
`default_nettype wire

FILE: sv/lzw_string_table_hash_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_string_table_hash_core: hashed LZW string table
// Open-addressing table keyed by (prefix code, pixel) with search, add and
// clear commands, one result per command.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                         | Handshake
//  ---------+-----------------------------------------------+-------------------
//  command  | in_cmd, in_prefix_code, in_pixel, in_new_code | start && !busy
//  result   | out_found, out_code                           | out_valid, 1 cycle
//
// Steps: a search or add goes from the transfer to the hash state, which reads
// the home slot, and on to the check state, which registers the result strobe
// when the home slot decides it; each extra probe along the chain adds one more
// check, as the read port fetches one row per cycle. With fewer than 4096
// slots the hash state first subtracts the table size once per cycle until
// the hash fits. Clear sweeps the table one row per cycle, then gives its result.
// Reset: after rst_n rises the same sweep empties the table; busy stays high
// meanwhile and no result is given for it.
// Stalls: the receiver cannot stall; each result is shown for one cycle.
// An unused command code returns found 0, code 0 and changes nothing.
//
module lzw_string_table_hash_core
  import lzwst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [PREFIX_W-1:0] in_prefix_code,
  input  wire logic [PIXEL_W-1:0]  in_pixel,
  input  wire logic [CODE_W-1:0]   in_new_code,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [CODE_W-1:0]        out_code
);

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [HASH_W-1:0] TABLE_LEN = HASH_W'(TABLE_ENTRIES);

  // Control registers
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              clr_reply_r, clr_reply_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [PIXEL_W-1:0]  pixel_r, pixel_nxt;
  logic [CODE_W-1:0]   ncode_r, ncode_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic                out_found_r, out_found_nxt;
  logic [CODE_W-1:0]   out_code_r, out_code_nxt;

  // Table memory, one row per slot
  logic [ROW_W-1:0] table_mem [TABLE_ENTRIES];
  logic [ROW_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;

  logic [CODE_W-1:0]   row_code;
  logic [PIXEL_W-1:0]  row_pixel;
  logic [PREFIX_W-1:0] row_prefix;
  logic [IDX_W-1:0]    idx_inc;
  logic                key_match;

  assign row_code   = rd_data_r[CODE_W-1:0];
  assign row_pixel  = rd_data_r[CODE_W +: PIXEL_W];
  assign row_prefix = rd_data_r[CODE_W + PIXEL_W +: PREFIX_W];
  assign key_match  = (row_prefix == prefix_r) && (row_pixel == pixel_r);

  // Advance the probe slot with wraparound.
  assign idx_inc = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_code  = out_code_r;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    prefix_r    <= prefix_nxt;
    pixel_r     <= pixel_nxt;
    ncode_r     <= ncode_nxt;
    hash_r      <= hash_nxt;
    out_found_r <= out_found_nxt;
    out_code_r  <= out_code_nxt;
  end

  // Sequencer: hash reduction, probe walk and clearing sweep.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    clr_reply_nxt = clr_reply_r;
    out_valid_nxt = 1'b0;
    cmd_nxt       = cmd_r;
    prefix_nxt    = prefix_r;
    pixel_nxt     = pixel_r;
    ncode_nxt     = ncode_r;
    hash_nxt      = hash_r;
    out_found_nxt = out_found_r;
    out_code_nxt  = out_code_r;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = {prefix_r, pixel_r, ncode_r};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt    = in_cmd;
          prefix_nxt = in_prefix_code;
          pixel_nxt  = in_pixel;
          ncode_nxt  = in_new_code;
          unique case (cmd_t'(in_cmd))
            CMD_SEARCH, CMD_ADD: begin
              hash_nxt  = HASH_W'(in_prefix_code ^ PREFIX_W'({in_pixel, PIX_SHIFT'(0)}));
              state_nxt = ST_HASH;
            end
            CMD_CLEAR: begin
              idx_nxt       = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            default: begin
              // Unused code: answer at once, touch nothing.
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b0;
              out_code_nxt  = '0;
            end
          endcase
        end
      end

      ST_HASH: begin
        // Reduce modulo the table size, then read the home slot.
        if (hash_r >= TABLE_LEN) begin
          hash_nxt = hash_r - TABLE_LEN;
        end else begin
          idx_nxt   = hash_r[IDX_W-1:0];
          rd_addr   = hash_r[IDX_W-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Read the next slot ahead in case the walk goes on.
        rd_addr = idx_inc;
        priority if (row_code == '0) begin
          if (cmd_r == CMD_ADD) begin
            wr_en = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_code_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else if ((cmd_r == CMD_SEARCH) && key_match) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_code_nxt  = row_code;
          state_nxt     = ST_IDLE;
        end else if (cnt_r == LAST_IDX) begin
          // Every slot visited: search misses, add is dropped.
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_code_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (idx_r == LAST_IDX) begin
          idx_nxt       = '0;
          state_nxt     = ST_IDLE;
          clr_reply_nxt = 1'b0;
          if (clr_reply_r) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_code_nxt  = '0;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A hit always carries a nonzero code.
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_code != '0)
    else $error("hit reported with an empty code");

  // A miss always carries code zero.
  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_code == '0)
    else $error("miss reported with a nonzero code");

  // A transfer either starts work or is answered at once.
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted command neither started nor answered");

  // A result follows a busy cycle or a transfer.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result strobe without pending work");

  // Walk counter never passes the table size.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK && $past(state_r) == ST_CHECK |-> cnt_r != '0)
    else $error("probe counter wrapped");

endmodule : lzw_string_table_hash_core
`default_nettype wire

FILE: tb/sv/lzw_string_table_hash_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_string_table_hash_core_tb: self-checking bench for the hashed LZW table
// Sends search, add and clear commands through the start/busy handshake and
// tracks every command in a software copy of the open-addressed table. Each
// result strobe is checked field by field against the oldest predicted lookup.
// ----------------------------------------------------------------------------
module lzw_string_table_hash_core_tb;
  import lzwst_pkg::*;

  // Quiet-cycle limit: covers the reset sweep, a full-table probe or a clear
  // sweep, plus sender gaps, with ample margin.
  localparam int QUIET_LIMIT  = 4 * TABLE_ENTRIES + 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 600;
  localparam int KEY_POOL     = 24;

  // Command code outside the enum; the block must answer it and change nothing.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } lookup_t;

  // Shadow string table: predicts one lookup per transferred command and
  // checks result strobes in order.
  class string_table_scoreboard;
    logic [PREFIX_W-1:0] slot_prefix [TABLE_ENTRIES];
    logic [PIXEL_W-1:0]  slot_pixel  [TABLE_ENTRIES];
    logic [CODE_W-1:0]   slot_code   [TABLE_ENTRIES];
    lookup_t             lookups_due [$];
    int                  mismatches;

    function new();
      foreach (slot_code[i]) begin
        slot_prefix[i] = '0;
        slot_pixel[i]  = '0;
        slot_code[i]   = '0;
      end
      mismatches = 0;
    endfunction

    function int unsigned home_slot(logic [PREFIX_W-1:0] prefix, logic [PIXEL_W-1:0] pixel);
      int unsigned entries;
      entries = TABLE_ENTRIES;
      return (32'(prefix) ^ (32'(pixel) << PIX_SHIFT)) % entries;
    endfunction

    function void note_transfer(logic [CMD_W-1:0] cmd, logic [PREFIX_W-1:0] prefix,
                                logic [PIXEL_W-1:0] pixel, logic [CODE_W-1:0] ncode);
      int unsigned slot;
      lookup_t     answer;
      answer = '0;
      case (cmd)
        CMD_SEARCH: begin
          slot = home_slot(prefix, pixel);
          for (int n = 0; n < TABLE_ENTRIES; n++) begin
            if (slot_code[slot] == '0) break;
            if (slot_prefix[slot] == prefix && slot_pixel[slot] == pixel) begin
              answer.found = 1'b1;
              answer.code  = slot_code[slot];
              break;
            end
            slot = (slot + 1) % TABLE_ENTRIES;
          end
        end
        CMD_ADD: begin
          // a full table drops the add
          slot = home_slot(prefix, pixel);
          for (int n = 0; n < TABLE_ENTRIES; n++) begin
            if (slot_code[slot] == '0) begin
              slot_prefix[slot] = prefix;
              slot_pixel[slot]  = pixel;
              slot_code[slot]   = ncode;
              break;
            end
            slot = (slot + 1) % TABLE_ENTRIES;
          end
        end
        CMD_CLEAR: begin
          foreach (slot_code[i]) slot_code[i] = '0;
        end
        default: ;
      endcase
      lookups_due.push_back(answer);
    endfunction

    function void report_mismatch(string what, logic [CODE_W:0] want, logic [CODE_W:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at %0t: expected 0x%0h, got 0x%0h", what, $realtime, want, got);
    endfunction

    function void check_result(logic found, logic [CODE_W-1:0] code);
      lookup_t want;
      if (lookups_due.size() == 0) begin
        report_mismatch("unexpected result", '0, {found, code});
        return;
      end
      want = lookups_due.pop_front();
      if (found !== want.found) report_mismatch("found", want.found, found);
      if (code !== want.code) report_mismatch("code", want.code, code);
    endfunction

    function int pending();
      return lookups_due.size();
    endfunction
  endclass

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [CMD_W-1:0]    in_cmd         = CMD_SEARCH;
  logic [PREFIX_W-1:0] in_prefix_code = '0;
  logic [PIXEL_W-1:0]  in_pixel       = '0;
  logic [CODE_W-1:0]   in_new_code    = '0;
  logic                busy;
  logic                out_valid;
  logic                out_found;
  logic [CODE_W-1:0]   out_code;

  string_table_scoreboard table_sb;
  int                     quiet_cycles = 0;
  bit                     sender_idles = 1'b1;

  // Keys for the random part; most share a few crowded home slots so that
  // probe chains, duplicates and wraparound get real traffic.
  logic [PREFIX_W-1:0] pool_prefix [KEY_POOL];
  logic [PIXEL_W-1:0]  pool_pixel  [KEY_POOL];

  lzw_string_table_hash_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_prefix_code (in_prefix_code),
    .in_pixel       (in_pixel),
    .in_new_code    (in_new_code),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_code       (out_code)
  );

  always #1 clk = ~clk;

  // Monitor: check a result strobe first, then note a command transfer, both
  // on values sampled just before the edge. Count cycles without any transfer or result strobe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) table_sb.check_result(out_found, out_code);
      if (start && !busy) table_sb.note_transfer(in_cmd, in_prefix_code, in_pixel, in_new_code);
      if (out_valid || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one command and hold it until the edge that transfers it.
  // Optionally drop start for a few cycles first so that gaps land at
  // every point of the block's work.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PREFIX_W-1:0] prefix,
                           input logic [PIXEL_W-1:0] pixel, input logic [CODE_W-1:0] ncode);
    int gap;
    if (sender_idles && $urandom_range(99) < 37) begin
      gap = $urandom_range(6, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_prefix_code <= prefix;
    in_pixel       <= pixel;
    in_new_code    <= ncode;
    do @(posedge clk); while (busy);
  endtask

  // Rebuild the random key pool; crowd keys onto four home slots, one of
  // them near the top of the table to exercise wraparound.
  task automatic refresh_key_pool();
    logic [PREFIX_W-1:0] crowded [4];
    crowded[0] = PREFIX_W'($urandom_range(4095, 4090));
    for (int b = 1; b < 4; b++) crowded[b] = PREFIX_W'($urandom);
    for (int k = 0; k < KEY_POOL; k++) begin
      pool_pixel[k] = PIXEL_W'($urandom);
      if ($urandom_range(99) < 70)
        pool_prefix[k] = crowded[$urandom_range(3)] ^ (PREFIX_W'(pool_pixel[k]) << PIX_SHIFT);
      else
        pool_prefix[k] = PREFIX_W'($urandom);
    end
  endtask

  initial begin
    int                  pick;
    int                  k;
    logic [PREFIX_W-1:0] noise_prefix;
    logic [PIXEL_W-1:0]  noise_pixel;
    logic [CODE_W-1:0]   noise_code;

    table_sb = new();
    refresh_key_pool();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table miss, extreme keys and codes, a collision,
    // a duplicate key, an add of code zero, a chain that wraps past the
    // last slot, a miss after probing, the unused command and a clear.
    send_item(CMD_SEARCH, 12'h000, 8'h00, 12'h000);
    send_item(CMD_ADD,    12'hFFF, 8'hFF, 12'hFFF);
    send_item(CMD_SEARCH, 12'hFFF, 8'hFF, 12'h000);
    send_item(CMD_ADD,    12'h000, 8'h00, 12'h001);
    send_item(CMD_SEARCH, 12'h000, 8'h00, 12'hFFF);
    send_item(CMD_ADD,    12'h010, 8'h01, 12'hABC);   // same home slot as key 0/0
    send_item(CMD_SEARCH, 12'h010, 8'h01, 12'h000);
    send_item(CMD_ADD,    12'h000, 8'h00, 12'h555);   // duplicate key lands further on
    send_item(CMD_SEARCH, 12'h000, 8'h00, 12'h000);
    send_item(CMD_ADD,    12'h123, 8'h45, 12'h000);   // zero code leaves the slot empty
    send_item(CMD_SEARCH, 12'h123, 8'h45, 12'h000);
    send_item(CMD_ADD,    12'hFFF, 8'h00, 12'h7FF);   // top slot
    send_item(CMD_ADD,    12'hF0F, 8'h0F, 12'h800);   // same home, wraps to slot 0 and on
    send_item(CMD_SEARCH, 12'hF0F, 8'h0F, 12'h000);
    send_item(CMD_SEARCH, 12'h020, 8'h02, 12'h000);   // miss at end of the chain
    send_item(CMD_UNUSED, 12'hFFF, 8'hFF, 12'hFFF);
    send_item(CMD_SEARCH, 12'hFFF, 8'hFF, 12'hFFF);
    send_item(CMD_CLEAR,  12'hFFF, 8'hFF, 12'hFFF);
    send_item(CMD_SEARCH, 12'hFFF, 8'hFF, 12'h000);
    send_item(CMD_SEARCH, 12'h000, 8'h00, 12'h000);

    // Random: mostly adds and searches on the crowded key pool, with noise
    // keys, rare clears and the unused command mixed in. A middle stretch
    // runs with start held high back to back.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_idles = !(i >= 250 && i < 400);
      pick         = $urandom_range(99);
      k            = $urandom_range(KEY_POOL - 1);
      noise_prefix = PREFIX_W'($urandom);
      noise_pixel  = PIXEL_W'($urandom);
      noise_code   = CODE_W'($urandom);
      if (pick < 45) begin
        if ($urandom_range(99) < 85)
          send_item(CMD_SEARCH, pool_prefix[k], pool_pixel[k], noise_code);
        else
          send_item(CMD_SEARCH, noise_prefix, noise_pixel, noise_code);
      end else if (pick < 83) begin
        send_item(CMD_ADD, pool_prefix[k], pool_pixel[k],
                  ($urandom_range(99) < 5) ? CODE_W'(0) : CODE_W'($urandom_range(4095, 1)));
      end else if (pick < 86) begin
        send_item(CMD_CLEAR, noise_prefix, noise_pixel, noise_code);
        refresh_key_pool();
      end else if (pick < 88) begin
        send_item(CMD_UNUSED, noise_prefix, noise_pixel, noise_code);
      end else begin
        send_item(CMD_SEARCH, noise_prefix, noise_pixel, noise_code);
      end
    end

    // Drain: drop start, let the last transfer reach the shadow table, wait
    // for every predicted lookup, then hold a few cycles for stray strobes.
    start <= 1'b0;
    @(posedge clk);
    while (table_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: lzw_string_table_hash_core.f
sv/lzwst_pkg.sv
sv/lzw_string_table_hash_core.sv
tb/sv/lzw_string_table_hash_core_tb.sv
